[rtl/core/kfe_pkg.sv]
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared types and constants of the K-line frame engine.
// ----------------------------------------------------------------------------
package kfe_pkg;

  localparam int MAX_RESULTS    = 6;
  localparam int COUNT_BITS     = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [7:0] FMT_LENGTH = 8'h80;
  localparam logic [7:0] FMT_SINGLE = 8'h81;

  localparam logic [7:0]  RST_TESTER_ADDRESS = 8'hF1;
  localparam logic [7:0]  RST_ECU_ADDRESS    = 8'h11;
  localparam logic        RST_HEADER_FORMAT  = 1'b1;
  localparam logic [7:0]  RST_RESPONSE_LIMIT = 8'd12;
  localparam logic [31:0] RST_TIMEOUT_TICKS  = 32'd2000;

  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_RECEIVE = 2'd1,
    MODE_TICK    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_LINE     = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_GOOD     = 3'd2,
    KIND_BAD      = 3'd3,
    KIND_TIMEOUT  = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    REG_TESTER_ADDRESS = 3'd0,
    REG_ECU_ADDRESS    = 3'd1,
    REG_HEADER_FORMAT  = 3'd2,
    REG_RESPONSE_LIMIT = 3'd3,
    REG_TIMEOUT_TICKS  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  tester_address;
    logic [7:0]  ecu_address;
    logic        header_format;
    logic [7:0]  response_limit;
    logic [31:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [7:0] position;
  } result_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]          count;
    result_t [MAX_RESULTS-1:0]      entry;
  } batch_t;

  function automatic result_t make_result(kind_t kind, logic [7:0] value,
                                          logic [7:0] position);
    result_t r;
    r.kind     = kind;
    r.value    = value;
    r.position = position;
    return r;
  endfunction

endpackage

[rtl/core/kfe_cfg_regs.sv]
// ----------------------------------------------------------------------------
// kfe_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module kfe_cfg_regs
  import kfe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tester_address <= RST_TESTER_ADDRESS;
      cfg.ecu_address    <= RST_ECU_ADDRESS;
      cfg.header_format  <= RST_HEADER_FORMAT;
      cfg.response_limit <= RST_RESPONSE_LIMIT;
      cfg.timeout_ticks  <= RST_TIMEOUT_TICKS;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TESTER_ADDRESS: cfg.tester_address <= cfg_data[7:0];
        REG_ECU_ADDRESS:    cfg.ecu_address    <= cfg_data[7:0];
        REG_HEADER_FORMAT:  cfg.header_format  <= cfg_data[0];
        REG_RESPONSE_LIMIT: cfg.response_limit <= cfg_data[7:0];
        REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/kfe_frame_core.sv]
// ----------------------------------------------------------------------------
// kfe_frame_core
// Input register, framing and deframing state, and the result batch logic.
// ----------------------------------------------------------------------------
module kfe_frame_core
  import kfe_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] data,
  input  logic [7:0] request_length,
  input  logic       request_last,
  input  logic       queue_free,
  output logic       load,
  output batch_t     batch
);

  localparam logic [TICK_COUNTER_BITS-1:0] IDLE_MAX = '1;

  logic       s1_valid;
  mode_t      s1_mode;
  logic [7:0] s1_data;
  logic [7:0] s1_len;
  logic       s1_last;

  logic [2:0] header_position, header_position_next;
  logic [7:0] expected_count, expected_count_next;
  logic [7:0] received_count, received_count_next;
  logic       addressed_to_me, addressed_to_me_next;
  logic [7:0] receive_sum, receive_sum_next;
  logic [7:0] transmit_sum, transmit_sum_next;
  logic       transmit_started, transmit_started_next;
  logic       awaiting_reply, awaiting_reply_next;
  logic [TICK_COUNTER_BITS-1:0] idle_ticks, idle_ticks_next;

  logic [7:0] fmt_byte;
  logic [7:0] first_sum;
  logic [7:0] cont_sum;
  logic [7:0] rx_sum;
  logic [7:0] rc_inc;
  logic       full;
  logic [TICK_COUNTER_BITS-1:0] idle_inc;
  logic       accept;

  assign load     = s1_valid && (queue_free || batch.count == '0);
  assign in_stall = s1_valid && !load;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= mode_t'(mode);
      s1_data <= data;
      s1_len  <= request_length;
      s1_last <= request_last;
    end
  end

  assign fmt_byte  = cfg.header_format ? FMT_SINGLE : FMT_LENGTH;
  assign first_sum = fmt_byte + cfg.ecu_address + cfg.tester_address
                     + (cfg.header_format ? 8'd0 : s1_len) + s1_data;
  assign cont_sum  = transmit_sum + s1_data;
  assign rx_sum    = receive_sum + s1_data;
  assign rc_inc    = received_count + 8'd1;
  assign full      = received_count >= cfg.response_limit;
  assign idle_inc  = (idle_ticks == IDLE_MAX) ? idle_ticks
                     : idle_ticks + {{(TICK_COUNTER_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    header_position_next  = header_position;
    expected_count_next   = expected_count;
    received_count_next   = received_count;
    addressed_to_me_next  = addressed_to_me;
    receive_sum_next      = receive_sum;
    transmit_sum_next     = transmit_sum;
    transmit_started_next = transmit_started;
    awaiting_reply_next   = awaiting_reply;
    idle_ticks_next       = idle_ticks;
    batch                 = '0;

    case (s1_mode)
      MODE_REQUEST: begin
        if (!transmit_started) begin
          transmit_started_next = 1'b1;
          awaiting_reply_next   = 1'b0;
          transmit_sum_next     = first_sum;
          batch.entry[0] = make_result(KIND_LINE, fmt_byte, 8'd0);
          batch.entry[1] = make_result(KIND_LINE, cfg.ecu_address, 8'd0);
          batch.entry[2] = make_result(KIND_LINE, cfg.tester_address, 8'd0);
          if (cfg.header_format) begin
            batch.entry[3] = make_result(KIND_LINE, s1_data, 8'd0);
            batch.entry[4] = make_result(KIND_LINE, first_sum, 8'd0);
            batch.count    = COUNT_BITS'(5);
          end else begin
            batch.entry[3] = make_result(KIND_LINE, s1_len, 8'd0);
            batch.entry[4] = make_result(KIND_LINE, s1_data, 8'd0);
            batch.entry[5] = make_result(KIND_LINE, first_sum, 8'd0);
            batch.count    = s1_last ? COUNT_BITS'(6) : COUNT_BITS'(5);
          end
        end else if (!cfg.header_format) begin
          transmit_sum_next = cont_sum;
          batch.entry[0] = make_result(KIND_LINE, s1_data, 8'd0);
          batch.entry[1] = make_result(KIND_LINE, cont_sum, 8'd0);
          batch.count    = s1_last ? COUNT_BITS'(2) : COUNT_BITS'(1);
        end
        if (s1_last) begin
          transmit_started_next = 1'b0;
          awaiting_reply_next   = 1'b1;
          header_position_next  = 3'd0;
          expected_count_next   = 8'd0;
          received_count_next   = 8'd0;
          addressed_to_me_next  = 1'b0;
          receive_sum_next      = 8'd0;
          idle_ticks_next       = '0;
        end
      end
      MODE_RECEIVE: begin
        if (awaiting_reply) begin
          idle_ticks_next = '0;
          case (header_position)
            3'd0: begin
              if (s1_data == FMT_SINGLE) begin
                expected_count_next = 8'd1;
              end else if (s1_data == FMT_LENGTH) begin
                expected_count_next = 8'd0;
              end
              addressed_to_me_next = 1'b0;
              receive_sum_next     = s1_data;
              header_position_next = 3'd1;
            end
            3'd1: begin
              if (s1_data == cfg.tester_address) begin
                addressed_to_me_next = 1'b1;
              end
              receive_sum_next     = rx_sum;
              header_position_next = 3'd2;
            end
            3'd2: begin
              if (s1_data == cfg.ecu_address) begin
                addressed_to_me_next = 1'b1;
              end else if (s1_data == cfg.tester_address) begin
                addressed_to_me_next = 1'b0;
              end
              receive_sum_next     = rx_sum;
              header_position_next = 3'd3;
            end
            3'd3: begin
              if (expected_count == 8'd1) begin
                if (full) begin
                  batch.entry[0]      = make_result(KIND_OVERFLOW, 8'd0, 8'd0);
                  batch.count         = COUNT_BITS'(1);
                  awaiting_reply_next = 1'b0;
                end else begin
                  if (addressed_to_me) begin
                    batch.entry[0] = make_result(KIND_DATA, s1_data, received_count);
                    batch.count    = COUNT_BITS'(1);
                  end
                  received_count_next  = rc_inc;
                  receive_sum_next     = rx_sum;
                  header_position_next = 3'd4;
                end
              end else begin
                expected_count_next  = s1_data;
                receive_sum_next     = rx_sum;
                header_position_next = 3'd4;
              end
            end
            default: begin
              if (expected_count == received_count) begin
                if (addressed_to_me) begin
                  if (receive_sum == s1_data) begin
                    batch.entry[0] = make_result(KIND_GOOD, 8'd0, received_count);
                  end else begin
                    batch.entry[0] = make_result(KIND_BAD, 8'd0, 8'd0);
                  end
                  batch.count         = COUNT_BITS'(1);
                  awaiting_reply_next = 1'b0;
                end else begin
                  header_position_next = 3'd0;
                  received_count_next  = 8'd0;
                  receive_sum_next     = 8'd0;
                end
              end else if (full) begin
                batch.entry[0]      = make_result(KIND_OVERFLOW, 8'd0, 8'd0);
                batch.count         = COUNT_BITS'(1);
                awaiting_reply_next = 1'b0;
              end else begin
                if (addressed_to_me) begin
                  batch.entry[0] = make_result(KIND_DATA, s1_data, received_count);
                  batch.count    = COUNT_BITS'(1);
                end
                received_count_next = rc_inc;
                receive_sum_next    = rx_sum;
              end
            end
          endcase
        end
      end
      MODE_TICK: begin
        if (awaiting_reply) begin
          idle_ticks_next = idle_inc;
          if (32'(idle_inc) >= cfg.timeout_ticks) begin
            batch.entry[0]      = make_result(KIND_TIMEOUT, 8'd0, 8'd0);
            batch.count         = COUNT_BITS'(1);
            awaiting_reply_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position  <= 3'd0;
      expected_count   <= 8'd0;
      received_count   <= 8'd0;
      addressed_to_me  <= 1'b0;
      receive_sum      <= 8'd0;
      transmit_sum     <= 8'd0;
      transmit_started <= 1'b0;
      awaiting_reply   <= 1'b0;
      idle_ticks       <= '0;
    end else if (load) begin
      header_position  <= header_position_next;
      expected_count   <= expected_count_next;
      received_count   <= received_count_next;
      addressed_to_me  <= addressed_to_me_next;
      receive_sum      <= receive_sum_next;
      transmit_sum     <= transmit_sum_next;
      transmit_started <= transmit_started_next;
      awaiting_reply   <= awaiting_reply_next;
      idle_ticks       <= idle_ticks_next;
    end
  end

endmodule

[rtl/core/kfe_result_queue.sv]
// ----------------------------------------------------------------------------
// kfe_result_queue
// Result register that holds one batch of words and shifts them out in order.
// ----------------------------------------------------------------------------
module kfe_result_queue
  import kfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  batch_t     batch,
  output logic       queue_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic [7:0] position,
  output logic       run_end
);

  logic [COUNT_BITS-1:0]     count;
  result_t [MAX_RESULTS-1:0] entry;
  logic                      take;

  assign out_valid  = count != '0;
  assign take       = out_valid && !out_stall;
  assign queue_free = (count == '0) || (count == COUNT_BITS'(1) && take);

  assign kind     = entry[0].kind;
  assign value    = entry[0].value;
  assign position = entry[0].position;
  assign run_end  = count == COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load && batch.count != '0) begin
      count <= batch.count;
    end else if (take) begin
      count <= count - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && batch.count != '0) begin
      entry <= batch.entry;
    end else if (take) begin
      entry <= {{$bits(result_t){1'b0}}, entry[MAX_RESULTS-1:1]};
    end
  end

endmodule

[rtl/core/kline_frame_engine_unit.sv]
// ----------------------------------------------------------------------------
// kline_frame_engine_unit
// K-line request framer and reply deframer with checksum, timeout and
// overflow detection.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid / in_stall  mode, data, request_length,
//                                           request_last
//  out      source     out_valid / out_stall kind, value, position, run_end
//  cfg      sink       cfg_write            cfg_index, cfg_data
//
// A word is taken into the input register, and its whole effect is then
// computed and loaded into the result register as a batch of up to six
// words. A word that yields one or no result leaves every cycle while the
// output is not stalled; a batch leaves one word at a time by the output port.
// Reset clears all control state and restores the register defaults.
// While the output is stalled, words with no result still pass.
// ----------------------------------------------------------------------------
module kline_frame_engine_unit
  import kfe_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic [7:0]                data,
  input  logic [7:0]                request_length,
  input  logic                      request_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                kind,
  output logic [7:0]                value,
  output logic [7:0]                position,
  output logic                      run_end
);

  cfg_t   cfg;
  batch_t batch;
  logic   load;
  logic   queue_free;

  kfe_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kfe_frame_core #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_frame_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .data           (data),
    .request_length (request_length),
    .request_last   (request_last),
    .queue_free     (queue_free),
    .load           (load),
    .batch          (batch)
  );

  kfe_result_queue u_result_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .batch      (batch),
    .queue_free (queue_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .position   (position),
    .run_end    (run_end)
  );

endmodule

[rtl/core/kfe_port_checker.sv]
// ----------------------------------------------------------------------------
// kfe_port_checker
// Port-level checks of the K-line frame engine, bound to the top level.
// ----------------------------------------------------------------------------
module kfe_port_checker
  import kfe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [7:0] value,
  input logic [7:0] position,
  input logic       run_end
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({kind, value, position, run_end}))
    else $error("stalled result word changed");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_LINE || kind == KIND_DATA || kind == KIND_GOOD ||
                   kind == KIND_BAD || kind == KIND_TIMEOUT || kind == KIND_OVERFLOW))
    else $error("result kind out of range");

  // Status words end the exchange and are the only result of their word.
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_GOOD || kind == KIND_BAD || kind == KIND_TIMEOUT ||
                  kind == KIND_OVERFLOW) |-> run_end && value == 8'd0)
    else $error("status word not last or carries a value");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word shown right after reset");

endmodule

bind kline_frame_engine_unit kfe_port_checker u_port_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .value     (value),
  .position  (position),
  .run_end   (run_end)
);
